FILE: rtl/tpt_pkg.sv
// Shared types, widths and command codes of the two-period pin toggler.
package tpt_pkg;

  localparam int TIME_WIDTH   = 32;
  localparam int COUNT_WIDTH  = 16;
  localparam int PERIOD_WIDTH = 32;
  localparam int LIMIT_WIDTH  = 16;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CMP_WIDTH = (TIME_WIDTH > PERIOD_WIDTH) ? TIME_WIDTH : PERIOD_WIDTH;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_RESUME  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LOW_PERIOD   = 3'd0,
    REG_HIGH_PERIOD  = 3'd1,
    REG_START_LEVEL  = 3'd2,
    REG_TOGGLE_LIMIT = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] low_period;
    logic [PERIOD_WIDTH-1:0] high_period;
    logic                    start_level;
    logic [LIMIT_WIDTH-1:0]  toggle_limit;
  } run_cfg_t;

  typedef struct packed {
    logic                   pin_level;
    logic                   active;
    logic [LIMIT_WIDTH-1:0] remaining_count;
  } result_t;

endpackage

FILE: rtl/tpt_cfg_regs.sv
// Configuration registers and the copies latched by a start request.
module tpt_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [tpt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [tpt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  logic                                  item_valid,
  input  logic [2:0]                            command,
  output tpt_pkg::run_cfg_t                     live_cfg,
  output tpt_pkg::run_cfg_t                     lat_cfg
);
  import tpt_pkg::*;

  run_cfg_t live_r, live_nxt;
  run_cfg_t lat_r, lat_nxt;

  always_comb begin
    live_nxt = live_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOW_PERIOD:   live_nxt.low_period   = PERIOD_WIDTH'(cfg_data);
        REG_HIGH_PERIOD:  live_nxt.high_period  = PERIOD_WIDTH'(cfg_data);
        REG_START_LEVEL:  live_nxt.start_level  = cfg_data[0];
        REG_TOGGLE_LIMIT: live_nxt.toggle_limit = LIMIT_WIDTH'(cfg_data);
        default:          live_nxt = live_r;
      endcase
    end
  end

  always_comb begin
    lat_nxt = lat_r;
    if (item_valid && (command == CMD_START)) begin
      lat_nxt = live_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      lat_r  <= '0;
    end else begin
      live_r <= live_nxt;
      lat_r  <= lat_nxt;
    end
  end

  assign live_cfg = live_r;
  assign lat_cfg  = lat_r;

endmodule

FILE: rtl/tpt_core.sv
// Toggler state and its combinational update for one request.
module tpt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic [2:0]        command,
  input  logic              forced_level,
  input  tpt_pkg::run_cfg_t live_cfg,
  input  tpt_pkg::run_cfg_t lat_cfg,
  output tpt_pkg::result_t  result
);
  import tpt_pkg::*;

  logic                   level_r, level_nxt;
  logic                   phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0]  elapsed_r, elapsed_nxt;
  logic [COUNT_WIDTH-1:0] remaining_r, remaining_nxt;
  logic                   counting_r, counting_nxt;
  logic                   running_r, running_nxt;
  logic                   started_r, started_nxt;

  logic [TIME_WIDTH-1:0]   elapsed_inc;
  logic [PERIOD_WIDTH-1:0] period;
  logic [COUNT_WIDTH-1:0]  remaining_dec;
  logic                    period_done;
  logic                    do_begin;
  run_cfg_t                src_cfg;

  assign elapsed_inc   = (&elapsed_r) ? elapsed_r : elapsed_r + TIME_WIDTH'(1);
  assign period        = phase_r ? lat_cfg.high_period : lat_cfg.low_period;
  assign period_done   = CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(period);
  assign remaining_dec = remaining_r - COUNT_WIDTH'(1);

  always_comb begin
    level_nxt     = level_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    remaining_nxt = remaining_r;
    counting_nxt  = counting_r;
    running_nxt   = running_r;
    started_nxt   = started_r;
    do_begin      = 1'b0;
    src_cfg       = lat_cfg;

    if (item_valid) begin
      case (command)
        CMD_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (running_r && period_done) begin
            level_nxt   = ~level_r;
            phase_nxt   = ~phase_r;
            elapsed_nxt = '0;
            if (counting_r) begin
              remaining_nxt = remaining_dec;
              if (remaining_dec == '0) begin
                running_nxt = 1'b0;
              end
            end
          end
        end
        CMD_START: begin
          src_cfg  = live_cfg;
          do_begin = 1'b1;
        end
        CMD_RESTART: begin
          do_begin = started_r;
        end
        CMD_STOP: begin
          level_nxt   = forced_level;
          running_nxt = 1'b0;
        end
        CMD_RESUME: begin
          if (started_r) begin
            running_nxt = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_begin) begin
        level_nxt     = src_cfg.start_level;
        phase_nxt     = src_cfg.start_level;
        elapsed_nxt   = '0;
        remaining_nxt = COUNT_WIDTH'(src_cfg.toggle_limit);
        counting_nxt  = (src_cfg.toggle_limit != '0);
        running_nxt   = 1'b1;
        started_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= 1'b0;
      phase_r     <= 1'b0;
      elapsed_r   <= '0;
      remaining_r <= '0;
      counting_r  <= 1'b0;
      running_r   <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      remaining_r <= remaining_nxt;
      counting_r  <= counting_nxt;
      running_r   <= running_nxt;
      started_r   <= started_nxt;
    end
  end

  // The result reflects the state after the request.
  assign result.pin_level       = level_nxt;
  assign result.active          = running_nxt;
  assign result.remaining_count = LIMIT_WIDTH'(remaining_nxt);

  // Nothing runs before a first start.
  a_run_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> started_r)
    else $error("running without a prior start");

  // Without counting the remaining count never moves from zero.
  a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !counting_r |-> (remaining_r == '0))
    else $error("remaining count moved while counting is off");

  // A start always leaves the toggler running from a cleared elapsed time.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && (command == CMD_START)) |=>
      (running_r && started_r && (elapsed_r == '0)))
    else $error("start did not begin a run");

endmodule

FILE: rtl/two_period_pin_toggler_unit.sv
// Top level of the two-period pin toggler: stream channels and result register.
//
//  channel | direction | payload                                          | handshake
//  in_     | slave     | tuser[2:0] command, tdata[0] forced_level        | tvalid/tready
//  out_    | master    | tdata[0] level, [1] active, [17:2] remaining     | tvalid/tready
//  cfg_    | slave     | cfg_index register, cfg_data value               | valid/ready
//
// Each request is handled combinationally; its result appears in the output register
// on the next cycle, so one request per cycle is sustained while out_tready stays high.
// The input is held off only while a result waits and out_tready is low.
// Reset is synchronous on rst_n low and clears all state and configuration to zero but out_data_r.
// Configuration writes are always accepted and apply at the next start.
module two_period_pin_toggler_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [0] forced_level
  input  logic [2:0]                           in_tuser,   // [2:0] command
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [23:0]                          out_tdata,  // [0] pin_level, [1] active,
                                                           // [17:2] remaining_count
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tpt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [tpt_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import tpt_pkg::*;

  logic     item_valid;
  run_cfg_t live_cfg;
  run_cfg_t lat_cfg;
  result_t  result;
  logic     out_valid_r, out_valid_nxt;
  result_t  out_data_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign item_valid = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  tpt_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .command    (in_tuser),
    .live_cfg   (live_cfg),
    .lat_cfg    (lat_cfg)
  );

  tpt_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .command      (in_tuser),
    .forced_level (in_tdata[0]),
    .live_cfg     (live_cfg),
    .lat_cfg      (lat_cfg),
    .result       (result)
  );

  assign out_valid_nxt = item_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (item_valid) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r.remaining_count, out_data_r.active,
                       out_data_r.pin_level};

  // Every accepted request yields a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid |=> out_valid_r)
    else $error("accepted request produced no result");

  // A stalled result blocks new requests so none is overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !item_valid)
    else $error("request accepted over a pending result");

endmodule

FILE: tb/tb_two_period_pin_toggler_unit.sv
// Self-checking stream testbench for two_period_pin_toggler_unit with a built-in predictor.
module tb_two_period_pin_toggler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tpt_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;
  localparam int MAX_PRINTS    = 100;
  localparam logic [2:0] CMD_LAST_CODE = 3'd7;

  // Tracks the toggler state and holds the expected result of every accepted request.
  class toggler_scoreboard;
    result_t                 pending_results[$];
    int unsigned             mismatches = 0;
    int unsigned             results_seen = 0;
    int unsigned             requests_seen = 0;
    int unsigned             reg_writes = 0;
    logic [PERIOD_WIDTH-1:0] low_period = '0, high_period = '0;
    logic [PERIOD_WIDTH-1:0] run_low = '0, run_high = '0;
    logic                    start_level = 1'b0, run_start = 1'b0;
    logic [LIMIT_WIDTH-1:0]  toggle_limit = '0, run_limit = '0;
    logic                    level = 1'b0, phase = 1'b0;
    logic [TIME_WIDTH-1:0]   elapsed = '0;
    logic [COUNT_WIDTH-1:0]  remaining = '0;
    logic                    counting = 1'b0, running = 1'b0, ever_started = 1'b0;

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
      reg_writes++;
      case (idx)
        REG_LOW_PERIOD:   low_period   = value[PERIOD_WIDTH-1:0];
        REG_HIGH_PERIOD:  high_period  = value[PERIOD_WIDTH-1:0];
        REG_START_LEVEL:  start_level  = value[0];
        REG_TOGGLE_LIMIT: toggle_limit = value[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function void launch_run();
      level        = run_start;
      phase        = run_start;
      elapsed      = '0;
      remaining    = COUNT_WIDTH'(run_limit);
      counting     = (run_limit != '0);
      running      = 1'b1;
      ever_started = 1'b1;
    endfunction

    // Advances the toggler by one request and queues the level, activity and count it leaves.
    function void note_request(logic [2:0] cmd, logic forced);
      logic [PERIOD_WIDTH-1:0] period;
      result_t                 res;
      requests_seen++;
      case (cmd)
        CMD_TICK: begin
          // Time keeps running while halted and sticks at its top value.
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (running) begin
            period = phase ? run_high : run_low;
            if (elapsed >= period) begin
              level   = ~level;
              phase   = ~phase;
              elapsed = '0;
              if (counting) begin
                remaining = remaining - 1'b1;
                if (remaining == '0) running = 1'b0;
              end
            end
          end
        end
        CMD_START: begin
          run_low   = low_period;
          run_high  = high_period;
          run_start = start_level;
          run_limit = toggle_limit;
          launch_run();
        end
        CMD_RESTART: if (ever_started) launch_run();
        CMD_STOP: begin
          level   = forced;
          running = 1'b0;
        end
        CMD_RESUME: if (ever_started) running = 1'b1;
        default: ;
      endcase
      res.pin_level       = level;
      res.active          = running;
      res.remaining_count = remaining[LIMIT_WIDTH-1:0];
      pending_results.push_back(res);
    endfunction

    task check_result(logic [23:0] tdata);
      result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h arrived with no request outstanding", tdata));
        return;
      end
      want = pending_results.pop_front();
      if (tdata[0] !== want.pin_level)
        report($sformatf("result %0d pin_level %b, expected %b",
                         results_seen, tdata[0], want.pin_level));
      if (tdata[1] !== want.active)
        report($sformatf("result %0d active %b, expected %b",
                         results_seen, tdata[1], want.active));
      if (tdata[17:2] !== want.remaining_count)
        report($sformatf("result %0d remaining_count %0d, expected %0d",
                         results_seen, tdata[17:2], want.remaining_count));
    endtask

    task finish_check();
      if (pending_results.size() != 0)
        report($sformatf("%0d results never arrived", pending_results.size()));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [7:0]                 in_tdata = '0;   // [0] forced_level
  logic [2:0]                 in_tuser = '0;   // [2:0] command
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [23:0]                out_tdata;       // [0] pin_level, [1] active, [17:2] remaining_count
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  toggler_scoreboard sb = new;
  bit                tx_idle = 1'b1;
  bit                hold_off_req = 1'b0;
  int unsigned       quiet_cycles = 0;

  two_period_pin_toggler_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Monitors sample the values that were stable before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata[0]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("tb_two_period_pin_toggler_unit: FAIL");
        $finish;
      end
    end
  end

  // Result receiver: random stalls per result, busy and quiet stretches, one long hold-off.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          rx_idle;
    taken   = 0;
    rx_idle = 1'b1;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 50 == 0) rx_idle = ($urandom_range(0, 2) != 0);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      taken++;
    end
  end

  task automatic send_item(logic [2:0] cmd, logic forced);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {7'b0, forced};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // The extra edge lets the monitor queue the last request before the count is read.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_regs(logic [PERIOD_WIDTH-1:0] low, logic [PERIOD_WIDTH-1:0] high,
                              logic start, logic [LIMIT_WIDTH-1:0] limit);
    reg_idx_t                  idx;
    logic [CFG_DATA_WIDTH-1:0] value;
    for (int r = 0; r < 4; r++) begin
      idx = reg_idx_t'(r);
      case (idx)
        REG_LOW_PERIOD:   value = CFG_DATA_WIDTH'(low);
        REG_HIGH_PERIOD:  value = CFG_DATA_WIDTH'(high);
        REG_START_LEVEL:  value = CFG_DATA_WIDTH'(start);
        default:          value = CFG_DATA_WIDTH'(limit);
      endcase
      cfg_index <= idx;
      cfg_data  <= value;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [PERIOD_WIDTH-1:0] low, high;
    logic                    start;
    logic [LIMIT_WIDTH-1:0]  limit;
    logic [2:0]              cmd;
    int unsigned             pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing started yet: restart and resume are ignored, time still runs.
    send_item(CMD_RESUME, 1'b1);
    send_item(CMD_RESTART, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_STOP, 1'b1);
    send_item(CMD_LAST_CODE, 1'b0);
    send_item(CMD_RESUME + 3'd1, 1'b1);
    wait_idle();

    // Zero periods toggle on every tick; the count runs out, then wraps after a resume.
    program_regs('0, '0, 1'b1, 16'd2);
    send_item(CMD_START, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_RESUME, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_STOP, 1'b0);
    send_item(CMD_RESUME, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_RESTART, 1'b1);
    send_item(CMD_LAST_CODE - 3'd1, 1'b0);
    wait_idle();

    // A long halt lets elapsed pass the period, so the tick after resume toggles at once.
    program_regs(32'd2, '1, 1'b0, '1);
    send_item(CMD_START, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_STOP, 1'b1);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_RESUME, 1'b0);
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin low = '0; high = '0; start = 1'b0; limit = '0; end
        1: begin low = '1; high = $urandom_range(0, 3); start = 1'b1; limit = '1; end
        2: begin
          low = $urandom_range(0, 5); high = $urandom_range(0, 5);
          start = 1'($urandom_range(0, 1)); limit = '0;
        end
        3: begin
          low = $urandom_range(0, 3); high = $urandom_range(0, 3);
          start = 1'b0; limit = LIMIT_WIDTH'(1);
        end
        4: begin
          low = $urandom_range(0, 8); high = $urandom_range(0, 8);
          start = 1'b1; limit = LIMIT_WIDTH'($urandom_range(2, 6));
        end
        5: begin
          low = $urandom; high = $urandom_range(0, 4);
          start = 1'($urandom_range(0, 1)); limit = LIMIT_WIDTH'($urandom_range(0, 65535));
        end
        6: begin
          low = $urandom_range(0, 2); high = '1;
          start = 1'b0; limit = LIMIT_WIDTH'($urandom_range(1, 4));
        end
        default: begin
          low = $urandom_range(0, 20); high = $urandom_range(0, 20);
          start = 1'($urandom_range(0, 1)); limit = LIMIT_WIDTH'($urandom_range(0, 10));
        end
      endcase
      program_regs(low, high, start, limit);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) tx_idle = ($urandom_range(0, 2) != 0);
        // Receiver holds off while requests keep coming, so the input must back up.
        if (p == 2 && i == 80) begin
          hold_off_req = 1'b1;
          tx_idle      = 1'b0;
        end
        if (p == 4 && i == 100) wait_idle();
        pick = $urandom_range(0, 99);
        if (i == 0)         cmd = CMD_START;
        else if (pick < 70) cmd = CMD_TICK;
        else if (pick < 76) cmd = CMD_START;
        else if (pick < 81) cmd = CMD_RESTART;
        else if (pick < 88) cmd = CMD_STOP;
        else if (pick < 95) cmd = CMD_RESUME;
        else                cmd = 3'($urandom_range(CMD_RESUME + 1, CMD_LAST_CODE));
        send_item(cmd, 1'($urandom_range(0, 1)));
      end
      wait_idle();
    end

    repeat (4) @(posedge clk);
    sb.finish_check();
    $display("Run covered %0d requests and %0d results over %0d register settings,",
             sb.requests_seen, sb.results_seen, sb.reg_writes / 4);
    $display("including zero and full-range periods, count wrap, halts and a long output stall.");
    if (sb.mismatches == 0 && sb.results_seen == sb.requests_seen) begin
      $display("tb_two_period_pin_toggler_unit: PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_two_period_pin_toggler_unit: FAIL");
    end
    $finish;
  end

endmodule
